// File: rtl/core/pls_pkg.sv
// Shared types and constants for the positional list store.
`default_nettype none

package pls_pkg;

	localparam int CapacityDef  = 32;
	localparam int DataWidthDef = 32;

	typedef enum logic [2:0] {
		FN_APPEND      = 3'd0,
		FN_INSERT_AT   = 3'd1,
		FN_READ_AT     = 3'd2,
		FN_READ_LAST   = 3'd3,
		FN_REMOVE_AT   = 3'd4,
		FN_REMOVE_LAST = 3'd5,
		FN_SEARCH      = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] value;
		logic [4:0]  position;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] data_out;
		logic [4:0]  found_index;
		logic [5:0]  entry_count;
	} rsp_t;

	// broadcast to every cell on an accepted request
	typedef struct packed {
		logic ins;         // open a gap at tgt and drop the value in
		logic rem;         // close up over tgt
		logic hit_at;      // cell at tgt is the one read
		logic hit_search;  // cells below lim compare against the value
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/pls_cell.sv
// One entry of the list: storage, shift, match flag and result token stage.
`default_nettype none

module pls_cell import pls_pkg::*; #(
	parameter int DATA_WIDTH = DataWidthDef,
	parameter int CMPW       = 6,
	parameter int IDXW       = 5,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire cell_ctl_t             ctl,
	input  wire logic [CMPW-1:0]       tgt,
	input  wire logic [CMPW-1:0]       lim,
	input  wire logic [DATA_WIDTH-1:0] val,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	output logic      [DATA_WIDTH-1:0] entry,
	input  wire logic                  tok_in_found,
	input  wire logic [DATA_WIDTH-1:0] tok_in_data,
	input  wire logic [IDXW-1:0]       tok_in_idx,
	output logic                       tok_found,
	output logic      [DATA_WIDTH-1:0] tok_data,
	output logic      [IDXW-1:0]       tok_idx
);

	localparam logic [CMPW-1:0] MyPos = CMPW'(INDEX);
	localparam logic [IDXW-1:0] MyIdx = IDXW'(INDEX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] cap_q;
	logic                  hit_q;
	logic                  hit_d;
	logic                  tok_found_q;
	logic [DATA_WIDTH-1:0] tok_data_q;
	logic [IDXW-1:0]       tok_idx_q;

	assign entry = entry_q;

	always_comb begin
		hit_d = (ctl.hit_at && MyPos == tgt)
			|| (ctl.hit_search && MyPos < lim && entry_q == val);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cap_q <= entry_q;
			if (ctl.ins) begin
				if (MyPos > tgt)
					entry_q <= left_data;
				else if (MyPos == tgt)
					entry_q <= val;
			end else if (ctl.rem && MyPos >= tgt) begin
				entry_q <= right_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			tok_found_q <= 1'b0;
		end else if (load) begin
			hit_q       <= hit_d;
			tok_found_q <= 1'b0;
		end else if (tok_in_found) begin
			tok_found_q <= 1'b1;
		end else begin
			tok_found_q <= hit_q;
		end
	end

	// token: lower cells win, so the first match survives to the end of the row
	always_ff @(posedge clk) begin
		if (load) begin
			tok_data_q <= '0;
			tok_idx_q  <= '0;
		end else if (tok_in_found) begin
			tok_data_q <= tok_in_data;
			tok_idx_q  <= tok_in_idx;
		end else if (hit_q) begin
			tok_data_q <= cap_q;
			tok_idx_q  <= MyIdx;
		end else begin
			tok_data_q <= '0;
			tok_idx_q  <= '0;
		end
	end

	assign tok_found = tok_found_q;
	assign tok_data  = tok_data_q;
	assign tok_idx   = tok_idx_q;

endmodule

`default_nettype wire

// File: rtl/core/positional_list_store_top.sv
// Top level of the positional list store: request decode, count and the row of cells.
// A request is taken only while busy is low; a new request may be taken in the
// cycle the previous result is strobed. The busy window is set by the result token, which
// ripples one cell per cycle down the row from the head to the tail.
// Reset: the count clears, entries are left as they are; done is never held off.
`default_nettype none

module positional_list_store_top import pls_pkg::*; #(
	parameter int CAPACITY   = CapacityDef,
	parameter int DATA_WIDTH = DataWidthDef
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	localparam int CW   = $clog2(CAPACITY + 1);   // count width
	localparam int IDXW = $clog2(CAPACITY);       // cell index width
	localparam int CMPW = (CW > 5) ? CW : 5;      // position compare width

	// ---- request side ----
	logic                  load;
	logic [CMPW-1:0]       pos_e;
	logic [CMPW-1:0]       cnt_e;
	logic [DATA_WIDTH+31:0] val_wide;
	logic [DATA_WIDTH-1:0] val;
	cell_ctl_t             ctl;
	logic [CMPW-1:0]       tgt;
	status_t               status_d;
	logic [CW-1:0]         count_d;
	logic                  full;
	logic                  empty;

	// ---- registered state ----
	logic [CW-1:0]   count_q;
	logic            busy_q;
	logic            done_q;
	logic [IDXW-1:0] cyc_q;
	status_t         status_q;
	logic            search_q;

	// ---- row of cells ----
	logic [DATA_WIDTH-1:0] entry_w     [CAPACITY];
	logic                  tok_found_w [CAPACITY];
	logic [DATA_WIDTH-1:0] tok_data_w  [CAPACITY];
	logic [IDXW-1:0]       tok_idx_w   [CAPACITY];

	// ---- result side ----
	logic [DATA_WIDTH+31:0] data_wide;
	logic [IDXW+4:0]        idx_wide;
	logic [CW+5:0]          cnt_wide;

	assign load     = start && !busy_q;
	assign busy     = busy_q;
	assign pos_e    = CMPW'(req.position);
	assign cnt_e    = CMPW'(count_q);
	assign val_wide = {{DATA_WIDTH{1'b0}}, req.value};
	assign val      = val_wide[DATA_WIDTH-1:0];
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);

	// Decode: pick what the cells do and the status/count known up front.
	// A search status is settled at the end from the token.
	always_comb begin
		ctl      = '0;
		tgt      = '0;
		status_d = ST_OK;
		count_d  = count_q;
		case (req.func)
			FN_APPEND, FN_INSERT_AT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					ctl.ins = 1'b1;
					// insert at or past the end is an append
					tgt     = (req.func == FN_APPEND || pos_e >= cnt_e) ? cnt_e : pos_e;
					count_d = count_q + CW'(1);
				end
			end
			FN_READ_AT: begin
				if (pos_e >= cnt_e) begin
					status_d = ST_RANGE;
				end else begin
					ctl.hit_at = 1'b1;
					tgt        = pos_e;
				end
			end
			FN_READ_LAST: begin
				if (empty) begin
					status_d = ST_RANGE;
				end else begin
					ctl.hit_at = 1'b1;
					tgt        = cnt_e - CMPW'(1);
				end
			end
			FN_REMOVE_AT: begin
				if (pos_e >= cnt_e) begin
					status_d = ST_RANGE;
				end else begin
					ctl.hit_at = 1'b1;
					ctl.rem    = 1'b1;
					tgt        = pos_e;
					count_d    = count_q - CW'(1);
				end
			end
			FN_REMOVE_LAST: begin
				// tail entry simply drops out of the count, no shifting
				if (empty) begin
					status_d = ST_RANGE;
				end else begin
					ctl.hit_at = 1'b1;
					tgt        = cnt_e - CMPW'(1);
					count_d    = count_q - CW'(1);
				end
			end
			FN_SEARCH: begin
				ctl.hit_search = 1'b1;
				status_d       = ST_MISS;
			end
			default: begin
				status_d = ST_RANGE;
			end
		endcase
	end

	// Control: count, busy window, one-cycle done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cyc_q    <= '0;
			status_q <= ST_OK;
			search_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				count_q  <= count_d;
				busy_q   <= 1'b1;
				cyc_q    <= '0;
				status_q <= status_d;
				search_q <= (req.func == FN_SEARCH);
			end else if (busy_q) begin
				if (cyc_q == IDXW'(CAPACITY - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cyc_q <= cyc_q + IDXW'(1);
				end
			end
		end
	end

	// The row: each cell sees its neighbours' entries for shifting, and the
	// token register of the cell before it.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;
		logic                  tin_found;
		logic [DATA_WIDTH-1:0] tin_data;
		logic [IDXW-1:0]       tin_idx;

		if (i == 0) begin : g_head
			assign left_d    = '0;
			assign tin_found = 1'b0;
			assign tin_data  = '0;
			assign tin_idx   = '0;
		end else begin : g_body
			assign left_d    = entry_w[i-1];
			assign tin_found = tok_found_w[i-1];
			assign tin_data  = tok_data_w[i-1];
			assign tin_idx   = tok_idx_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_d = entry_w[i];
		end else begin : g_inner
			assign right_d = entry_w[i+1];
		end

		pls_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CMPW       (CMPW),
			.IDXW       (IDXW),
			.INDEX      (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.load         (load),
			.ctl          (ctl),
			.tgt          (tgt),
			.lim          (cnt_e),
			.val          (val),
			.left_data    (left_d),
			.right_data   (right_d),
			.entry        (entry_w[i]),
			.tok_in_found (tin_found),
			.tok_in_data  (tin_data),
			.tok_in_idx   (tin_idx),
			.tok_found    (tok_found_w[i]),
			.tok_data     (tok_data_w[i]),
			.tok_idx      (tok_idx_w[i])
		);
	end

	// Result: the tail token holds the first hit once the ripple is through.
	assign data_wide = {32'b0, tok_data_w[CAPACITY-1]};
	assign idx_wide  = {5'b0, tok_idx_w[CAPACITY-1]};
	assign cnt_wide  = {6'b0, count_q};

	always_comb begin
		rsp             = '0;
		rsp.entry_count = cnt_wide[5:0];
		if (search_q) begin
			rsp.status      = tok_found_w[CAPACITY-1] ? ST_OK : ST_MISS;
			rsp.found_index = idx_wide[4:0];
		end else begin
			rsp.status   = status_q;
			rsp.data_out = data_wide[31:0];
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire
